// File: rtl/snms_pkg.sv
package snms_pkg;

    localparam int MAX_BOXES = 1024;
    localparam int MAX_OUT   = 64;
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int OCNT_W    = $clog2(MAX_OUT + 1);
    localparam int WAIT_W    = 3;
    localparam int IOU_LAT   = 5;
    localparam int PIX_LAT   = 2;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_IOU_THR = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PAD_L   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAD_T   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IN_W    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IN_H    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INV_W   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INV_H   = 3'd6;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RK_A, ST_RK_B, ST_RK_C, ST_RK_D,
        ST_SP_A, ST_SP_B, ST_SP_C, ST_SP_D, ST_SP_E, ST_SP_F, ST_SP_W,
        ST_OT_A, ST_OT_B, ST_OT_C, ST_OT_W, ST_OT_F
    } t_state;

    typedef struct packed {
        logic [15:0] iou_thr;
        logic [11:0] pad_l;
        logic [11:0] pad_t;
        logic [12:0] in_w;
        logic [12:0] in_h;
        logic [19:0] inv_w;
        logic [19:0] inv_h;
    } t_cfg;

    typedef struct packed {
        logic             load_we;
        logic             gs_from_ord;
        logic [IDX_W-1:0] gs_addr;
        logic [IDX_W-1:0] os_addr;
        logic             ord_we;
        logic [IDX_W-1:0] ord_waddr;
        logic [IDX_W-1:0] ord_wdata;
        logic             supp_we;
        logic [IDX_W-1:0] supp_waddr;
        logic             supp_wdata;
        logic             latch_si;
        logic             latch_a;
        logic             latch_b;
        logic             load_pend;
        logic             push_pend;
        logic             push_last;
    } t_cmd;

    typedef struct packed {
        logic sc_gt;
        logic sc_eq;
        logic supp_bit;
        logic kill;
        logic pend_v;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [15:0] out_left;
        logic [15:0] out_top;
        logic [15:0] out_right;
        logic [15:0] out_bottom;
        logic [15:0] out_score;
        logic [7:0]  out_class;
        logic        last_result;
    } t_res;

endpackage

// File: rtl/snms_box_if.sv
interface snms_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [15:0]        box_w;
    logic [15:0]        box_h;
    logic [15:0]        score;
    logic [7:0]         class_id;
    logic               last_box;

    modport source(output valid, box_x, box_y, box_w, box_h, score, class_id, last_box,
                   input ready);
    modport sink(input valid, box_x, box_y, box_w, box_h, score, class_id, last_box,
                 output ready);
endinterface

// File: rtl/snms_res_if.sv
interface snms_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_right;
    logic [15:0] out_bottom;
    logic [15:0] out_score;
    logic [7:0]  out_class;
    logic        last_result;

    modport source(output valid, out_left, out_top, out_right, out_bottom, out_score,
                   out_class, last_result, input ready);
    modport sink(input valid, out_left, out_top, out_right, out_bottom, out_score,
                 out_class, last_result, output ready);
endinterface

// File: rtl/snms_ram.sv
module snms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/snms_cfg.sv
module snms_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output snms_pkg::t_cfg    o_cfg
);
    import snms_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iou_thr <= 16'd29491;
            r_cfg.pad_l   <= '0;
            r_cfg.pad_t   <= '0;
            r_cfg.in_w    <= 13'd640;
            r_cfg.in_h    <= 13'd640;
            r_cfg.inv_w   <= 20'd4096;
            r_cfg.inv_h   <= 20'd4096;
        end else if (wr) begin
            unique case (idx)
                REG_IOU_THR: r_cfg.iou_thr <= pwdata[15:0];
                REG_PAD_L:   r_cfg.pad_l   <= pwdata[11:0];
                REG_PAD_T:   r_cfg.pad_t   <= pwdata[11:0];
                REG_IN_W:    r_cfg.in_w    <= pwdata[12:0];
                REG_IN_H:    r_cfg.in_h    <= pwdata[12:0];
                REG_INV_W:   r_cfg.inv_w   <= pwdata[19:0];
                REG_INV_H:   r_cfg.inv_h   <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_IOU_THR: prdata = {16'd0, r_cfg.iou_thr};
            REG_PAD_L:   prdata = {20'd0, r_cfg.pad_l};
            REG_PAD_T:   prdata = {20'd0, r_cfg.pad_t};
            REG_IN_W:    prdata = {19'd0, r_cfg.in_w};
            REG_IN_H:    prdata = {19'd0, r_cfg.in_h};
            REG_INV_W:   prdata = {12'd0, r_cfg.inv_w};
            REG_INV_H:   prdata = {12'd0, r_cfg.inv_h};
            default:     prdata = '0;
        endcase
    end
endmodule

// File: rtl/snms_ctrl.sv
module snms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    output logic           o_in_ready,
    input  snms_pkg::t_sts i_sts,
    output snms_pkg::t_cmd o_cmd
);
    import snms_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_i, n_i;
    logic [CNT_W-1:0]    r_j, n_j;
    logic [CNT_W-1:0]    r_rank, n_rank;
    logic [WAIT_W-1:0]   r_wcnt, n_wcnt;
    logic [OCNT_W-1:0]   r_ocnt, n_ocnt;
    logic [CNT_W-1:0]    last_pos;
    logic [CNT_W-1:0]    i_inc;
    logic [CNT_W-1:0]    j_inc;
    logic                i_last_pos;
    logic                j_last_pos;
    t_cmd                cmd;

    assign last_pos   = r_count - CNT_W'(1);
    assign i_inc      = r_i + CNT_W'(1);
    assign j_inc      = r_j + CNT_W'(1);
    assign i_last_pos = (r_i == last_pos);
    assign j_last_pos = (r_j == last_pos);
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_rank  <= '0;
            r_wcnt  <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_rank  <= n_rank;
            r_wcnt  <= n_wcnt;
            r_ocnt  <= n_ocnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_i        = r_i;
        n_j        = r_j;
        n_rank     = r_rank;
        n_wcnt     = r_wcnt;
        n_ocnt     = r_ocnt;
        cmd        = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready  = 1'b1;
                cmd.gs_addr = r_count[IDX_W-1:0];
                if (i_in_valid) begin
                    // drop the item once the store is full
                    if (r_count < CNT_W'(MAX_BOXES)) begin
                        cmd.load_we = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end
                    if (i_in_last) begin
                        n_i     = '0;
                        n_state = ST_RK_A;
                    end
                end
            end
            ST_RK_A: begin
                cmd.gs_addr = r_i[IDX_W-1:0];
                n_state     = ST_RK_B;
            end
            ST_RK_B: begin
                cmd.latch_si = 1'b1;
                cmd.gs_addr  = '0;
                n_j          = '0;
                n_rank       = '0;
                n_state      = ST_RK_C;
            end
            ST_RK_C: begin
                // count boxes that sort ahead of box i
                cmd.gs_addr = j_inc[IDX_W-1:0];
                if (i_sts.sc_gt || (i_sts.sc_eq && (r_j < r_i))) begin
                    n_rank = r_rank + CNT_W'(1);
                end
                if (j_last_pos) begin
                    n_state = ST_RK_D;
                end else begin
                    n_j = j_inc;
                end
            end
            ST_RK_D: begin
                cmd.ord_we     = 1'b1;
                cmd.ord_waddr  = r_rank[IDX_W-1:0];
                cmd.ord_wdata  = r_i[IDX_W-1:0];
                cmd.supp_we    = 1'b1;
                cmd.supp_waddr = r_i[IDX_W-1:0];
                cmd.supp_wdata = 1'b0;
                if (i_last_pos) begin
                    n_i     = '0;
                    n_state = ST_SP_A;
                end else begin
                    n_i     = i_inc;
                    n_state = ST_RK_A;
                end
            end
            ST_SP_A: begin
                cmd.os_addr = r_i[IDX_W-1:0];
                n_state     = ST_SP_B;
            end
            ST_SP_B: begin
                cmd.gs_from_ord = 1'b1;
                if (i_sts.supp_bit) begin
                    if (i_last_pos) begin
                        n_i     = '0;
                        n_ocnt  = '0;
                        n_state = ST_OT_A;
                    end else begin
                        n_i     = i_inc;
                        n_state = ST_SP_A;
                    end
                end else begin
                    n_state = ST_SP_C;
                end
            end
            ST_SP_C: begin
                cmd.latch_a = 1'b1;
                if (i_last_pos) begin
                    n_i     = '0;
                    n_ocnt  = '0;
                    n_state = ST_OT_A;
                end else begin
                    n_j     = i_inc;
                    n_state = ST_SP_D;
                end
            end
            ST_SP_D: begin
                cmd.os_addr = r_j[IDX_W-1:0];
                n_state     = ST_SP_E;
            end
            ST_SP_E: begin
                cmd.gs_from_ord = 1'b1;
                if (i_sts.supp_bit) begin
                    if (!j_last_pos) begin
                        n_j     = j_inc;
                        n_state = ST_SP_D;
                    end else if (i_last_pos) begin
                        n_i     = '0;
                        n_ocnt  = '0;
                        n_state = ST_OT_A;
                    end else begin
                        n_i     = i_inc;
                        n_state = ST_SP_A;
                    end
                end else begin
                    n_state = ST_SP_F;
                end
            end
            ST_SP_F: begin
                cmd.latch_b = 1'b1;
                n_wcnt      = '0;
                n_state     = ST_SP_W;
            end
            ST_SP_W: begin
                if (r_wcnt == WAIT_W'(IOU_LAT)) begin
                    if (i_sts.kill) begin
                        cmd.supp_we    = 1'b1;
                        cmd.supp_waddr = r_j[IDX_W-1:0];
                        cmd.supp_wdata = 1'b1;
                    end
                    if (!j_last_pos) begin
                        n_j     = j_inc;
                        n_state = ST_SP_D;
                    end else if (i_last_pos) begin
                        n_i     = '0;
                        n_ocnt  = '0;
                        n_state = ST_OT_A;
                    end else begin
                        n_i     = i_inc;
                        n_state = ST_SP_A;
                    end
                end else begin
                    n_wcnt = r_wcnt + WAIT_W'(1);
                end
            end
            ST_OT_A: begin
                cmd.os_addr = r_i[IDX_W-1:0];
                n_state     = ST_OT_B;
            end
            ST_OT_B: begin
                cmd.gs_from_ord = 1'b1;
                if (i_sts.supp_bit) begin
                    if (i_last_pos) begin
                        n_state = ST_OT_F;
                    end else begin
                        n_i     = i_inc;
                        n_state = ST_OT_A;
                    end
                end else begin
                    n_state = ST_OT_C;
                end
            end
            ST_OT_C: begin
                cmd.latch_b = 1'b1;
                n_wcnt      = '0;
                n_state     = ST_OT_W;
            end
            ST_OT_W: begin
                if (r_wcnt == WAIT_W'(PIX_LAT)) begin
                    // hold the newest survivor back until we know whether it is the last
                    if (!i_sts.pend_v || i_sts.out_free) begin
                        cmd.push_pend = i_sts.pend_v;
                        cmd.load_pend = 1'b1;
                        n_ocnt        = r_ocnt + OCNT_W'(1);
                        if (i_last_pos || (r_ocnt == OCNT_W'(MAX_OUT - 1))) begin
                            n_state = ST_OT_F;
                        end else begin
                            n_i     = i_inc;
                            n_state = ST_OT_A;
                        end
                    end
                end else begin
                    n_wcnt = r_wcnt + WAIT_W'(1);
                end
            end
            ST_OT_F: begin
                if (!i_sts.pend_v) begin
                    n_count = '0;
                    n_state = ST_LOAD;
                end else if (i_sts.out_free) begin
                    cmd.push_pend = 1'b1;
                    cmd.push_last = 1'b1;
                    n_count       = '0;
                    n_state       = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("box count above capacity");
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> (r_i < r_count))
        else $error("position outside the frame");
    a_supp_later: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.supp_we && cmd.supp_wdata) |-> (r_j > r_i))
        else $error("suppression of a box not after the keeper");
    a_out_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= OCNT_W'(MAX_OUT))
        else $error("too many results");
`endif
endmodule

// File: rtl/snms_dp.sv
module snms_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  snms_pkg::t_cfg     i_cfg,
    input  snms_pkg::t_cmd     i_cmd,
    output snms_pkg::t_sts     o_sts,
    input  logic signed [15:0] i_box_x,
    input  logic signed [15:0] i_box_y,
    input  logic [15:0]        i_box_w,
    input  logic [15:0]        i_box_h,
    input  logic [15:0]        i_score,
    input  logic [7:0]         i_class_id,
    output logic               o_valid,
    input  logic               i_ready,
    output snms_pkg::t_res     o_res
);
    import snms_pkg::*;

    function automatic logic [12:0] to_pix(logic signed [18:0] q, logic [12:0] lim);
        logic signed [18:0] top;
        top = $signed({2'b00, lim, 4'b0000});
        if (q <= 19'sd0) begin
            return '0;
        end else if (q >= top) begin
            return lim;
        end
        return q[16:4];
    endfunction

    function automatic logic [15:0] sat16(logic [32:0] p);
        if (|p[32:28]) begin
            return 16'hFFFF;
        end
        return p[27:12];
    endfunction

    logic [IDX_W-1:0] gs_raddr;
    logic [63:0]      geo_rdata;
    logic [23:0]      sc_rdata;
    logic [IDX_W-1:0] ord_rdata;
    logic [0:0]       supp_rdata;

    assign gs_raddr = i_cmd.gs_from_ord ? ord_rdata : i_cmd.gs_addr;

    snms_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_geo (
        .i_clk(i_clk), .i_we(i_cmd.load_we), .i_waddr(i_cmd.gs_addr),
        .i_wdata({i_box_h, i_box_w, i_box_y, i_box_x}),
        .i_raddr(gs_raddr), .o_rdata(geo_rdata)
    );
    snms_ram #(.WIDTH(24), .DEPTH(MAX_BOXES)) u_sc (
        .i_clk(i_clk), .i_we(i_cmd.load_we), .i_waddr(i_cmd.gs_addr),
        .i_wdata({i_class_id, i_score}),
        .i_raddr(gs_raddr), .o_rdata(sc_rdata)
    );
    snms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_ord (
        .i_clk(i_clk), .i_we(i_cmd.ord_we), .i_waddr(i_cmd.ord_waddr),
        .i_wdata(i_cmd.ord_wdata),
        .i_raddr(i_cmd.os_addr), .o_rdata(ord_rdata)
    );
    snms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_supp (
        .i_clk(i_clk), .i_we(i_cmd.supp_we), .i_waddr(i_cmd.supp_waddr),
        .i_wdata(i_cmd.supp_wdata),
        .i_raddr(i_cmd.os_addr), .o_rdata(supp_rdata)
    );

    // keeper (a) and candidate (b) boxes
    logic [15:0]        r_si;
    logic signed [15:0] r_ax, r_ay, r_bx, r_by;
    logic [15:0]        r_aw, r_ah, r_bw, r_bh, r_bs;
    logic [7:0]         r_ac, r_bc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_si) begin
            r_si <= sc_rdata[15:0];
        end
        if (i_cmd.latch_a) begin
            r_ax <= $signed(geo_rdata[15:0]);
            r_ay <= $signed(geo_rdata[31:16]);
            r_aw <= geo_rdata[47:32];
            r_ah <= geo_rdata[63:48];
            r_ac <= sc_rdata[23:16];
        end
        if (i_cmd.latch_b) begin
            r_bx <= $signed(geo_rdata[15:0]);
            r_by <= $signed(geo_rdata[31:16]);
            r_bw <= geo_rdata[47:32];
            r_bh <= geo_rdata[63:48];
            r_bs <= sc_rdata[15:0];
            r_bc <= sc_rdata[23:16];
        end
    end

    // overlap test, one register level per step
    logic signed [18:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic signed [18:0] ix0, ix1, iy0, iy1, iw, ih;
    logic [16:0]        r_iw, r_ih, r_bw16, r_bh16;
    logic [33:0]        r_area_a, r_area_b, r_inter, r_inter2, r_inter3;
    logic [34:0]        r_uni;
    logic [33:0]        r_plo;
    logic [32:0]        r_phi;
    logic               r_over;

    assign ax0 = 19'(r_ax);
    assign ay0 = 19'(r_ay);
    assign bx0 = 19'(r_bx);
    assign by0 = 19'(r_by);
    assign ax1 = ax0 + $signed({3'b000, r_aw});
    assign ay1 = ay0 + $signed({3'b000, r_ah});
    assign bx1 = bx0 + $signed({3'b000, r_bw});
    assign by1 = by0 + $signed({3'b000, r_bh});
    assign ix0 = (ax0 > bx0) ? ax0 : bx0;
    assign iy0 = (ay0 > by0) ? ay0 : by0;
    assign ix1 = (ax1 < bx1) ? ax1 : bx1;
    assign iy1 = (ay1 < by1) ? ay1 : by1;
    assign iw  = ix1 - ix0 + 19'sd16;
    assign ih  = iy1 - iy0 + 19'sd16;

    always_ff @(posedge i_clk) begin
        r_iw     <= iw[18] ? 17'd0 : iw[16:0];
        r_ih     <= ih[18] ? 17'd0 : ih[16:0];
        r_bw16   <= {1'b0, r_bw} + 17'd16;
        r_bh16   <= {1'b0, r_bh} + 17'd16;
        r_area_a <= ({1'b0, r_aw} + 17'd16) * ({1'b0, r_ah} + 17'd16);
        r_inter  <= r_iw * r_ih;
        r_area_b <= r_bw16 * r_bh16;
        r_uni    <= {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
        r_inter2 <= r_inter;
        r_plo    <= i_cfg.iou_thr * r_uni[17:0];
        r_phi    <= i_cfg.iou_thr * r_uni[34:18];
        r_inter3 <= r_inter2;
        r_over   <= {2'b00, r_inter3, 16'd0} > ({1'b0, r_phi, 18'd0} + {18'd0, r_plo});
    end

    // coordinate conversion
    logic signed [18:0] px0, px1, py0, py1, dx, dy;
    logic [12:0]        r_pl, r_pt, r_pr, r_pb;
    logic [32:0]        r_ml, r_mt, r_mr, r_mb;

    assign dx  = $signed({3'b000, i_cfg.pad_l, 4'b0000});
    assign dy  = $signed({3'b000, i_cfg.pad_t, 4'b0000});
    assign px0 = 19'(r_bx) - dx;
    assign py0 = 19'(r_by) - dy;
    assign px1 = 19'(r_bx) + $signed({3'b000, r_bw}) - dx;
    assign py1 = 19'(r_by) + $signed({3'b000, r_bh}) - dy;

    always_ff @(posedge i_clk) begin
        r_pl <= to_pix(px0, i_cfg.in_w);
        r_pr <= to_pix(px1, i_cfg.in_w);
        r_pt <= to_pix(py0, i_cfg.in_h);
        r_pb <= to_pix(py1, i_cfg.in_h);
        r_ml <= {20'd0, r_pl} * {13'd0, i_cfg.inv_w};
        r_mr <= {20'd0, r_pr} * {13'd0, i_cfg.inv_w};
        r_mt <= {20'd0, r_pt} * {13'd0, i_cfg.inv_h};
        r_mb <= {20'd0, r_pb} * {13'd0, i_cfg.inv_h};
    end

    // pending survivor and output register
    t_res r_pend, r_out;
    logic r_pend_v, r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.load_pend) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.push_pend) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.push_pend) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pend) begin
            r_pend.out_left    <= sat16(r_ml);
            r_pend.out_top     <= sat16(r_mt);
            r_pend.out_right   <= sat16(r_mr);
            r_pend.out_bottom  <= sat16(r_mb);
            r_pend.out_score   <= r_bs;
            r_pend.out_class   <= r_bc;
            r_pend.last_result <= 1'b0;
        end
        // last_result is the low bit of the item
        if (i_cmd.push_pend) begin
            r_out <= {r_pend[$bits(t_res)-1:1], i_cmd.push_last};
        end
    end

    assign o_valid        = r_out_v;
    assign o_res          = r_out;
    assign o_sts.sc_gt    = sc_rdata[15:0] > r_si;
    assign o_sts.sc_eq    = sc_rdata[15:0] == r_si;
    assign o_sts.supp_bit = supp_rdata[0];
    assign o_sts.kill     = r_over && (r_ac == r_bc);
    assign o_sts.pend_v   = r_pend_v;
    assign o_sts.out_free = !r_out_v || i_ready;
endmodule

// File: rtl/sorted_class_aware_nms.sv
// Class-aware greedy NMS over one frame of up to 1024 boxes. Boxes are taken
// one per cycle until the last mark; boxes past capacity are dropped. After the
// last box the block stops taking input while it works on the frame of n boxes:
// ranking by descending score (stable) is limited by the single read port of the
// score memory; suppression is paced by the pipelined overlap test (three 17x17,
// one 16x18 and one 16x17 product); output walks the ranked positions and gives
// up to 64 results, the last one flagged. Results leave through an output
// register, so a stalled consumer only pauses the output walk.
module sorted_class_aware_nms (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snms_box_if.sink    i_box,
    snms_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import snms_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;
    t_res res;
    logic in_ready;
    logic out_valid;

    snms_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready), .o_cfg(cfg)
    );

    snms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_box.valid), .i_in_last(i_box.last_box), .o_in_ready(in_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    snms_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_cmd(cmd), .o_sts(sts),
        .i_box_x(i_box.box_x), .i_box_y(i_box.box_y), .i_box_w(i_box.box_w),
        .i_box_h(i_box.box_h), .i_score(i_box.score), .i_class_id(i_box.class_id),
        .o_valid(out_valid), .i_ready(o_res.ready), .o_res(res)
    );

    assign i_box.ready       = in_ready;
    assign o_res.valid       = out_valid;
    assign o_res.out_left    = res.out_left;
    assign o_res.out_top     = res.out_top;
    assign o_res.out_right   = res.out_right;
    assign o_res.out_bottom  = res.out_bottom;
    assign o_res.out_score   = res.out_score;
    assign o_res.out_class   = res.out_class;
    assign o_res.last_result = res.last_result;
endmodule
